[rtl/pci_pkg.sv]
`default_nettype none
package pci_pkg;
  localparam int DW = 32;
  localparam int FB = 15;
  localparam int LW = 23;
  localparam int OW = 8;
  localparam int AW = 3;
  localparam int PW = 2 * DW;

  localparam logic [AW-1:0] REG_TARGET = 3'd0;
  localparam logic [AW-1:0] REG_KP     = 3'd1;
  localparam logic [AW-1:0] REG_KI     = 3'd2;
  localparam logic [AW-1:0] REG_KD     = 3'd3;
  localparam logic [AW-1:0] REG_DT     = 3'd4;
  localparam logic [AW-1:0] REG_MIN    = 3'd5;
  localparam logic [AW-1:0] REG_MAX    = 3'd6;

  localparam logic [LW-1:0] MAX_RESET = 23'd8355840;
  localparam logic signed [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

  // Saturate a wider signed value to the data width.
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+1:0] v);
    logic signed [DW+1:0] hi_lim;
    logic signed [DW+1:0] lo_lim;
    hi_lim = {{2{1'b0}}, POS_LIM};
    lo_lim = {{2{1'b1}}, NEG_LIM};
    if (v > hi_lim) return POS_LIM;
    if (v < lo_lim) return NEG_LIM;
    return v[DW-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/pci_stream_if.sv]
`default_nettype none
interface pci_stream_if #(parameter int W = 32) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/pci_serial_mul.sv]
`default_nettype none
// Bit-serial signed fractional multiplier: one multiplier bit per cycle.
// Result is the exact product shifted right by the fraction bits (floor),
// saturated to the data width.
module pci_serial_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [pci_pkg::DW-1:0] a,
  input  wire logic signed [pci_pkg::DW-1:0] b,
  output logic                             done,
  output logic signed [pci_pkg::DW-1:0]    result
);
  import pci_pkg::*;

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [DW-1:0]        mplier;
  logic [5:0]           count;
  logic                 busy;
  logic signed [PW-1:0] shifted;
  logic signed [PW-1:0] addend;

  // Partial product of the current bit; the sign bit carries negative weight.
  always_comb begin
    addend = '0;
    if (mplier[0]) begin
      addend = (count == 6'(DW - 1)) ? -mcand : mcand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        count  <= '0;
        acc    <= '0;
        mcand  <= PW'(a);
        mplier <= b;
      end else if (busy) begin
        acc    <= acc + addend;
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        count  <= count + 6'd1;
        if (count == 6'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Arithmetic shift floors; then saturate.
  always_comb begin
    shifted = acc >>> FB;
    if (shifted > PW'(POS_LIM)) result = POS_LIM;
    else if (shifted < PW'(NEG_LIM)) result = NEG_LIM;
    else result = shifted[DW-1:0];
  end
endmodule
`default_nettype wire

[rtl/pci_serial_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle: (num << FB) / den,
// truncating toward zero, saturated to the data width.
module pci_serial_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [pci_pkg::DW-1:0] num,
  input  wire logic signed [pci_pkg::DW-1:0] den,
  output logic                               done,
  output logic signed [pci_pkg::DW-1:0]      result
);
  import pci_pkg::*;

  localparam int NB = DW + FB;

  logic [NB-1:0] dividend;
  logic [DW:0]   rem;
  logic [NB-1:0] quot;
  logic [DW-1:0] dmag;
  logic          neg;
  logic          busy;
  logic [6:0]    count;
  logic [DW:0]   trial;
  logic [NB:0]   mag_ext;

  assign trial = {rem[DW-1:0], dividend[NB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= '0;
        quot     <= '0;
        neg      <= num[DW-1] ^ den[DW-1];
        dividend <= {(num[DW-1] ? DW'(-num) : DW'(num)), {FB{1'b0}}};
        dmag     <= den[DW-1] ? DW'(-den) : DW'(den);
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, dmag}) begin
          rem  <= trial - {1'b0, dmag};
          quot <= {quot[NB-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NB-2:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign the magnitude and saturate.
  always_comb begin
    mag_ext = {1'b0, quot};
    if (neg) begin
      if (mag_ext >= (NB+1)'({1'b1, {(DW-1){1'b0}}})) result = NEG_LIM;
      else result = -$signed(quot[DW-1:0]);
    end else begin
      if (mag_ext > (NB+1)'(POS_LIM)) result = POS_LIM;
      else result = quot[DW-1:0];
    end
  end
endmodule
`default_nettype wire

[rtl/pid_conditional_integration_core.sv]
`default_nettype none
// PID temperature controller with conditional-integration anti-windup.
// A request runs through the derivative divide, which forms 47 quotient
// bits, and then four multiplies (error*dt, p, i, d). The limit test
// follows; when the sum lands inside the limits, a fifth multiply for the
// updated integral runs before the output is formed. All of them run on
// one serial multiplier and one serial divider.
// With dt zero the drive of 0 is valid in the cycle after acceptance and
// the state is untouched. The result sits in an output register. A new
// request is taken in the cycle after that result has been accepted.
module pid_conditional_integration_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  pci_stream_if.sink       in_ch,
  pci_stream_if.source     out_ch
);
  import pci_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_MDT  = 4'd2;
  localparam logic [3:0] S_MP   = 4'd3;
  localparam logic [3:0] S_MI   = 4'd4;
  localparam logic [3:0] S_MD   = 4'd5;
  localparam logic [3:0] S_TEST = 4'd6;
  localparam logic [3:0] S_MI2  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;

  logic signed [DW-1:0] target, kp, ki, kd, dt;
  logic [LW-1:0]        lim_lo, lim_hi;
  logic signed [DW-1:0] last_error, integ_acc;
  logic signed [DW-1:0] err, cand, deriv, p_term, i_term, d_term;
  logic [3:0]           state;
  logic                 out_valid;
  logic [OW-1:0]        drive;

  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [DW-1:0] mul_a, mul_b, mul_res, div_res;
  logic signed [DW+1:0] sum;
  logic signed [DW+1:0] clamped;
  logic                 in_range;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0; kp <= '0; ki <= '0; kd <= '0; dt <= '0;
      lim_lo <= '0; lim_hi <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: target <= cfg_data;
        REG_KP:     kp <= cfg_data;
        REG_KI:     ki <= cfg_data;
        REG_KD:     kd <= cfg_data;
        REG_DT:     dt <= cfg_data;
        REG_MIN:    lim_lo <= cfg_data[LW-1:0];
        REG_MAX:    lim_hi <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign sum = (DW+2)'(p_term) + (DW+2)'(i_term) + (DW+2)'(d_term);
  assign in_range = (sum >= $signed({3'b0, lim_lo})) && (sum <= $signed({3'b0, lim_hi}));

  // Raise to the lower limit, then lower to the upper one.
  always_comb begin
    clamped = sum;
    if (clamped < $signed({3'b0, lim_lo})) clamped = $signed({3'b0, lim_lo});
    if (clamped > $signed({3'b0, lim_hi})) clamped = $signed({3'b0, lim_hi});
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = err;
    mul_b = dt;
    unique case (state)
      S_MP:  begin mul_a = err;       mul_b = kp; end
      S_MI:  begin mul_a = integ_acc; mul_b = ki; end
      S_MD:  begin mul_a = deriv;     mul_b = kd; end
      S_MI2: begin mul_a = integ_acc; mul_b = ki; end
      default: begin mul_a = err;     mul_b = dt; end
    endcase
  end

  pci_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_res)
  );

  pci_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(sat_dw((DW+2)'(err) - (DW+2)'(last_error))), .den(dt),
    .done(div_done), .result(div_res)
  );

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = drive;

  // Sequencer: one pass of the control law per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      last_error <= '0;
      integ_acc  <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (dt == '0) begin
              drive     <= '0;
              out_valid <= 1'b1;
            end else begin
              err       <= sat_dw((DW+2)'(target) - (DW+2)'($signed(in_ch.data)));
              div_start <= 1'b1;
              state     <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= S_DIV;
        S_DIV: if (div_done) begin
          deriv      <= div_res;
          last_error <= err;
          mul_start  <= 1'b1;
          state      <= S_MDT;
        end
        S_MDT: if (mul_done) begin
          cand      <= sat_dw((DW+2)'(integ_acc) + (DW+2)'(mul_res));
          mul_start <= 1'b1;
          state     <= S_MP;
        end
        S_MP: if (mul_done) begin
          p_term    <= mul_res;
          mul_start <= 1'b1;
          state     <= S_MI;
        end
        S_MI: if (mul_done) begin
          i_term    <= mul_res;
          mul_start <= 1'b1;
          state     <= S_MD;
        end
        S_MD: if (mul_done) begin
          d_term <= mul_res;
          state  <= S_TEST;
        end
        S_TEST: begin
          if (in_range) begin
            integ_acc <= cand;
            mul_start <= 1'b1;
            state     <= S_MI2;
          end else begin
            state <= S_OUT;
          end
        end
        S_MI2: if (mul_done) begin
          i_term <= mul_res;
          state  <= S_OUT;
        end
        S_OUT: begin
          drive     <= clamped[FB+OW-1:FB];
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("request taken while busy");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result not presented");
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start)) else $error("both units started");
endmodule
`default_nettype wire

[dv/pci_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module pci_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  pci_stream_if            in_ch,
  pci_stream_if            out_ch,
  output int               errors,
  output int               pending
);
  import pci_pkg::*;

  // Shadow copy of the controller registers and state.
  logic signed [31:0] setpoint, kp, ki, kd, step_dt;
  logic [LW-1:0]      lim_lo, lim_hi;
  logic signed [31:0] prev_err, integral;
  logic [OW-1:0]      drive_q[$];

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return POS_LIM;
    if (v < -64'sd2147483648) return NEG_LIM;
    return v[31:0];
  endfunction

  // Fixed-point product, floored, then saturated.
  function automatic logic signed [31:0] qmul(input longint a, input longint b);
    longint prod;
    prod = a * b;
    return clip32(prod >>> FB);
  endfunction

  // Fixed-point quotient, truncated toward zero, then saturated.
  function automatic logic signed [31:0] qdiv(input longint n, input longint d);
    longint quo;
    quo = (n <<< FB) / d;
    return clip32(quo);
  endfunction

  // Run one control step on the shadow state and return the expected drive.
  function automatic logic [OW-1:0] control_step(input logic signed [31:0] sample);
    longint err, cand, deriv, p, i, d, sum, lo, hi;
    if (step_dt == 0) return '0;
    lo = longint'(lim_lo);
    hi = longint'(lim_hi);
    err = clip32(longint'(setpoint) - longint'(sample));
    cand = clip32(longint'(integral) + qmul(err, step_dt));
    deriv = qdiv(clip32(err - longint'(prev_err)), step_dt);
    prev_err = err[31:0];
    p = qmul(err, kp);
    i = qmul(integral, ki);
    d = qmul(deriv, kd);
    sum = p + i + d;
    // The integral only moves while the output stays inside the limits.
    if (sum >= lo && sum <= hi) begin
      integral = cand[31:0];
      i = qmul(integral, ki);
      sum = p + i + d;
    end
    if (sum < lo) sum = lo;
    if (sum > hi) sum = hi;
    return sum[FB+OW-1:FB];
  endfunction

  assign pending = drive_q.size();

  always @(posedge clk) begin
    if (rst) begin
      setpoint <= '0; kp <= '0; ki <= '0; kd <= '0; step_dt <= '0;
      lim_lo <= '0; lim_hi <= MAX_RESET;
      prev_err <= '0; integral <= '0;
      drive_q.delete();
      errors <= 0;
    end else begin
      // Register writes must happen only while the block is idle; the block does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: setpoint = cfg_data;
          REG_KP:     kp = cfg_data;
          REG_KI:     ki = cfg_data;
          REG_KD:     kd = cfg_data;
          REG_DT:     step_dt = cfg_data;
          REG_MIN:    lim_lo = cfg_data[LW-1:0];
          REG_MAX:    lim_hi = cfg_data[LW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) drive_q.push_back(control_step(in_ch.data));
      // Compare each accepted result with the oldest expectation.
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          $error("drive: no request pending, actual %0d", out_ch.data);
          errors <= errors + 1;
        end else begin
          logic [OW-1:0] want;
          want = drive_q.pop_front();
          if (out_ch.data !== want) begin
            $error("drive: expected %0d, actual %0d", want, out_ch.data);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[dv/tb_pid_conditional_integration_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_pid_conditional_integration_core;
  import pci_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEMS_PER_SET = 235;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending, cycles;
  int          send_idle, recv_stall;
  int          hold_trig, hold_seen, hold_left;
  logic [31:0] setpoint;

  pci_stream_if #(.W(DW)) in_ch (clk);
  pci_stream_if #(.W(OW)) out_ch (clk);

  pid_conditional_integration_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  pci_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_cfg(input logic [31:0] tgt, input logic [31:0] p, input logic [31:0] i,
                          input logic [31:0] d, input logic [31:0] dt,
                          input logic [31:0] lo, input logic [31:0] hi);
    put_reg(REG_TARGET, tgt);
    put_reg(REG_KP, p);
    put_reg(REG_KI, i);
    put_reg(REG_KD, d);
    put_reg(REG_DT, dt);
    put_reg(REG_MIN, lo);
    put_reg(REG_MAX, hi);
    cfg_we <= 1'b0;
    setpoint = tgt;
    @(posedge clk);
  endtask

  // Offer one request and wait until it is taken.
  task automatic send(input logic [31:0] sample);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= sample;
    @(posedge clk iff (in_ch.valid && in_ch.ready));
  endtask

  // Stop offering and let every expected result drain. The first edge lets
  // the checker record the request taken at the previous one.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly samples near the setpoint so the integrator gets to work.
  function automatic logic [31:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return setpoint + $urandom_range(0, 32'h40000) - 32'h20000;
    if (sel < 8) return $urandom;
    return sel[0] ? 32'h80000000 : 32'h7FFFFFFF;
  endfunction

  task automatic sane_cfg();
    load_cfg($urandom_range(20, 300) << FB, $urandom_range(0, 4 << FB),
             $urandom_range(0, 1 << FB), $urandom_range(0, 1 << FB) - (1 << 14),
             $urandom_range(1, 1 << FB), $urandom_range(0, 40) << FB,
             ($urandom_range(100, 255) << FB) | $urandom_range(0, 32'h7FFF));
  endtask

  task automatic wild_cfg();
    load_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int phase;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_trig = 0;
    setpoint = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset config has a zero time step, so drive stays 0.
    send(32'h80000000);
    send(32'h7FFFFFFF);
    drain();

    // Plain heater settings around 25.0 degrees.
    load_cfg(25 << FB, 2 << FB, 32'h0CCD, 32'h4000, 32'h0CCD, 0, 255 << FB);
    send(32'h80000000);
    send(32'h7FFFFFFF);
    send(32'h00000000);
    send(32'hFFFFFFFF);
    send(25 << FB);
    send(24 << FB);
    send(26 << FB);
    drain();

    // Inverted limits: result pinned to the upper limit.
    load_cfg(25 << FB, 2 << FB, 32'h0CCD, 32'h4000, 32'h0CCD, 200 << FB, 10 << FB);
    send(20 << FB);
    send(30 << FB);
    send(32'h80000000);
    drain();

    // Widest upper limit: integer part beyond 8 bits gets masked.
    load_cfg(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, 32'h7FFFFF);
    send(0);
    send(32'h80000000);
    send(32'h12345678);
    drain();

    // Extreme gains and a negative time step.
    load_cfg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7FFFFF, 0);
    send(32'h7FFFFFFF);
    send(32'h80000000);
    send(32'hDEADBEEF);
    drain();

    // Random phases with sender gaps, result back-pressure, or both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      sane_cfg();
      for (n = 0; n < ITEMS_PER_SET; n++) begin
        if (phase == 0 && n == 50) hold_trig = hold_trig + 1;
        // Sender pause until all results are back.
        if (n == 120) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        send(pick_sample());
      end
      drain();
      if (phase == 3) wild_cfg();
      else sane_cfg();
      for (n = 0; n < ITEMS_PER_SET; n++) begin
        send(phase == 3 ? $urandom : pick_sample());
      end
      drain();
    end

    // End with the largest and smallest register values written.
    load_cfg(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             0, 32'h7FFFFF);
    for (n = 0; n < 20; n++) send($urandom);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/pci_pkg.sv
rtl/pci_stream_if.sv
rtl/pci_serial_mul.sv
rtl/pci_serial_div.sv
rtl/pid_conditional_integration_core.sv
dv/pci_checker.sv
dv/tb_pid_conditional_integration_core.sv
